// ===== rtl/sidec_pkg.sv =====
// ----------------------------------------------------------------------------
// sidec_pkg
// Shared constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidec_pkg;

  // default width of the input value
  localparam int VALUE_BITS_DEF = 32;

  // ascii codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;

  // shift-add-3 correction for one bcd digit
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;

endpackage

// ===== rtl/sidec_dabble.sv =====
// ----------------------------------------------------------------------------
// sidec_dabble
// Iterative binary to bcd converter: one magnitude bit is shifted into the
// bcd register per cycle, with add-3 correction on every digit.
// ----------------------------------------------------------------------------
module sidec_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIG_COUNT  = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [VALUE_BITS-1:0]    mag,
  output logic                     done,
  output logic [4*DIG_COUNT-1:0]   bcd
);
  import sidec_pkg::*;

  localparam int BCD_W = 4 * DIG_COUNT;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [CNT_W-1:0]      cnt;
  logic                  running;
  logic [BCD_W-1:0]      bcd_adj;

  // add-3 on every digit that is five or more
  always_comb begin
    for (int i = 0; i < DIG_COUNT; i++) begin
      if (bcd[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= CNT_W'(VALUE_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: shift magnitude into bcd
  always_ff @(posedge clk) begin
    if (load) begin
      bin <= mag;
      bcd <= '0;
    end else if (running) begin
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_BITS-1]};
    end
  end

  // checks
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> (running && cnt == CNT_W'(VALUE_BITS)))
    else $error("conversion did not start on load");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    running |-> (cnt != '0))
    else $error("running with empty bit counter");

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a signed integer as decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its magnitude goes
// through a shift-add-3 bcd loop that handles one bit per cycle; once the
// loop is done the characters follow at one per cycle: '-' first for a
// negative value, then the digits, with last_char set on the final one.
// strobe marks each character for exactly one cycle and cannot be held
// off, so the receiver must take every character as it comes. An item
// occupies the block until its last character; busy drops in the cycle the
// last character is shown, so the next value may be accepted then. Zero
// gives the single character '0' and the most negative value is printed
// in full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sidec_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         strobe,
  output logic [7:0]                   char_code,
  output logic                         last_char
);
  import sidec_pkg::*;

  localparam int DIG_COUNT = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int PTR_W     = $clog2(DIG_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGITS
  } state_t;

  state_t                  state;
  logic                    negative;
  logic [PTR_W-1:0]        ptr;
  logic [PTR_W-1:0]        lead;
  logic [VALUE_BITS-1:0]   vraw;
  logic [VALUE_BITS-1:0]   mag_in;
  logic                    load;
  logic                    dab_done;
  logic [4*DIG_COUNT-1:0]  bcd;
  logic [3:0]              lead_digit;
  logic [3:0]              ptr_digit;

  // magnitude as unsigned, covers the most negative value
  assign vraw   = value;
  assign mag_in = vraw[VALUE_BITS-1] ? VALUE_BITS'(~vraw + 1'b1) : vraw;
  assign busy   = (state != ST_IDLE);
  assign load   = start && !busy;

  sidec_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIG_COUNT  (DIG_COUNT)
  ) u_dabble (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .mag  (mag_in),
    .done (dab_done),
    .bcd  (bcd)
  );

  // leading nonzero digit, zero when all digits are zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIG_COUNT; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead = PTR_W'(i);
      end
    end
  end

  assign lead_digit = bcd[lead*4 +: 4];
  assign ptr_digit  = bcd[ptr*4 +: 4];

  // sequencer and character output
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            negative <= vraw[VALUE_BITS-1];
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (dab_done) begin
            strobe <= 1'b1;
            if (negative) begin
              char_code <= ASCII_MINUS;
              last_char <= 1'b0;
              ptr       <= lead;
              state     <= ST_DIGITS;
            end else begin
              char_code <= ASCII_ZERO + {4'd0, lead_digit};
              last_char <= (lead == '0);
              ptr       <= lead - 1'b1;
              state     <= (lead == '0) ? ST_IDLE : ST_DIGITS;
            end
          end
        end
        ST_DIGITS: begin
          strobe    <= 1'b1;
          char_code <= ASCII_ZERO + {4'd0, ptr_digit};
          last_char <= (ptr == '0);
          ptr       <= ptr - 1'b1;
          if (ptr == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_char) |-> !busy)
    else $error("still busy after the final character");
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (char_code == ASCII_MINUS ||
                (char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + {4'd0, DIGIT_MAX})))
    else $error("character is neither minus nor a digit");
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    dab_done |-> (state == ST_CONV))
    else $error("conversion finished outside the conversion phase");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> busy)
    else $error("accepted item did not make the block busy");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed integer to decimal ASCII converter.
// A table of hand-picked values runs first. Where the text is obvious it is
// typed in; the other rows use the bench's own decimal renderer. Random values
// of every digit count follow. Each character shown on strobe is compared with
// the oldest expected character, and gaps between commands are random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sidec_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 200;
  localparam int IDLE_PCT     = 17;
  localparam int MAX_GAP      = 45;
  localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + 13);
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DIR_ROWS     = 18;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         busy;
  logic                         strobe;
  logic [7:0]                   char_code;
  logic                         last_char;

  char_t char_expect_q[$];
  int    fail_count   = 0;
  int    cycle_count  = 0;
  int    items_sent   = 0;
  int    neg_items    = 0;
  int    chars_seen   = 0;
  bit    quiet_stretch = 1'b0;

  // directed values; an empty text means the renderer supplies the characters
  logic signed [VALUE_BITS-1:0] dir_value [DIR_ROWS] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sh7fff_ffff, 32'sh8000_0000, -32'sd2147483647, 32'sd1000000000,
    -32'sd999999999, 32'sd123456789, -32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA,
    32'sd4096
  };
  string dir_text [DIR_ROWS] = '{
    "0", "1", "-1", "9", "10", "-10", "99", "100",
    "2147483647", "-2147483648", "-2147483647", "1000000000",
    "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .value    (value),
    .strobe   (strobe),
    .char_code(char_code),
    .last_char(last_char)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii test failed");
      $finish;
    end
  end

  // decimal text of a value, sign first, then digits msd first
  function automatic void render_decimal(input logic signed [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [7:0]            digits [0:19];
    int                    nd;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    nd  = 0;
    if (mag == 0) begin
      char_expect_q.push_back('{ASCII_ZERO, 1'b1});
      return;
    end
    while (mag != 0) begin
      digits[nd] = ASCII_ZERO + 8'(mag % 10);
      mag        = mag / 10;
      nd++;
    end
    if (v[VALUE_BITS-1]) char_expect_q.push_back('{ASCII_MINUS, 1'b0});
    for (int i = nd - 1; i >= 0; i--) begin
      char_expect_q.push_back('{digits[i], i == 0});
    end
  endfunction

  // typed-in text as expected characters
  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_expect_q.push_back('{8'(s[i]), i == s.len() - 1});
    end
  endfunction

  // random value spread over all digit counts and both extremes
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] r;
    int                    k;
    case ($urandom_range(3))
      0: r = $urandom;
      1: r = $urandom_range(999);
      2: begin
        k = $urandom_range(9);
        r = 10 ** k;
        r = r + $urandom_range(2) - 1;
      end
      default: r = 32'h7fff_ffff - $urandom_range(3);
    endcase
    // ones' complement keeps the most negative value reachable
    if ($urandom_range(1)) r = ~r;
    return r;
  endfunction

  // issue one command, optionally after an idle gap; returns once accepted
  task automatic issue_value(input logic signed [VALUE_BITS-1:0] v, input string text);
    int gap;
    if (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (text.len() != 0) queue_text(text);
    else render_decimal(v);
    items_sent++;
    if (v[VALUE_BITS-1]) neg_items++;
  endtask

  // character checker
  always @(posedge clk) begin
    char_t exp_c;
    if (!rst && strobe) begin
      chars_seen++;
      if (char_expect_q.size() == 0) begin
        $error("unexpected character %0d, last_char %0b", char_code, last_char);
        fail_count++;
      end else begin
        exp_c = char_expect_q.pop_front();
        if (char_code !== exp_c.code) begin
          $error("char_code: expected %0d, actual %0d", exp_c.code, char_code);
          fail_count++;
        end
        if (last_char !== exp_c.last) begin
          $error("last_char: expected %0b, actual %0b", exp_c.last, last_char);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_value(dir_value[i], dir_text[i]);
    end

    // random part with a stretch of back-to-back commands
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_stretch = (i >= 60 && i < 130);
      issue_value(pick_value(), "");
    end
    start <= 1'b0;

    // drain
    while (char_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (char_expect_q.size() != 0) begin
      $error("%0d expected characters never arrived", char_expect_q.size());
      fail_count++;
    end

    $display("converted %0d values (%0d negative) into %0d characters",
             items_sent, neg_items, chars_seen);
    if (fail_count == 0) begin
      $display("signed_int_to_decimal_ascii test passed");
    end else begin
      $display("signed_int_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
